@@ rtl/psrwt_pkg.sv @@
package psrwt_pkg;

	localparam int DEF_WINDOW      = 512;
	localparam int DEF_NUM_SENDERS = 16;

	localparam int SND_W    = 4;
	localparam int SEQ_W    = 32;
	localparam int STATUS_W = 2;
	// Number of bitmap bits held in one memory word.
	localparam int WORD_W   = 64;
	localparam int BIT_W    = 6;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERRUN = 2'd2;
	localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd3;

	localparam logic FUNC_SET = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_SCAN,
		S_WRITE,
		S_RDNEXT,
		S_LDNEXT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic eval;
		logic scan;
		logic wb;
		logic ldw;
		logic push;
		logic clr;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic need_scan;
		logic scan_stop;
		logic scan_wrap;
		logic out_free;
	} stat_t;

endpackage

@@ rtl/psrwt_ctrl.sv @@
module psrwt_ctrl
	import psrwt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	input  stat_t stat,
	output logic  s_tready,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = stat.need_scan ? S_SCAN : S_RESP;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_stop) begin
					state_d = S_RESP;
				end else if (stat.scan_wrap) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.wb  = 1'b1;
				state_d = S_RDNEXT;
			end
			S_RDNEXT: begin
				cmd.rd  = 1'b1;
				state_d = S_LDNEXT;
			end
			S_LDNEXT: begin
				cmd.ldw = 1'b1;
				state_d = S_SCAN;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

@@ rtl/psrwt_dp.sv @@
module psrwt_dp
	import psrwt_pkg::*;
#(
	parameter int WINDOW      = DEF_WINDOW,
	parameter int NUM_SENDERS = DEF_NUM_SENDERS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  logic                  in_func,
	input  logic [SND_W-1:0]      in_sender,
	input  logic [SEQ_W-1:0]      in_seq,
	input  logic                  m_tready,
	output logic                  m_tvalid,
	output logic [STATUS_W-1:0]   out_status,
	output logic [SEQ_W-1:0]      out_base,
	output stat_t                 stat
);

	localparam int WB    = $clog2(WINDOW);
	localparam int WB6   = WB - BIT_W;
	localparam int WPS   = WINDOW / WORD_W;
	localparam int SB    = (NUM_SENDERS > 1) ? $clog2(NUM_SENDERS) : 1;
	localparam int AW    = SB + WB6;
	localparam int TOTAL = NUM_SENDERS * WPS;

	logic [WORD_W-1:0] bits_mem [TOTAL];
	logic [SEQ_W-1:0]  base_mem [NUM_SENDERS];

	logic                func_q;
	logic [SND_W-1:0]    sender_q;
	logic                in_range_q;
	logic [SEQ_W-1:0]    pos_q;
	logic [SEQ_W-1:0]    base_q;
	logic [WORD_W-1:0]   rword_q;
	logic [WORD_W-1:0]   word_q;
	logic [AW-1:0]       waddr_q;
	logic [AW-1:0]       clr_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [SEQ_W-1:0]    res_base_q;
	logic                m_tvalid_q;
	logic [STATUS_W-1:0] m_status_q;
	logic [SEQ_W-1:0]    m_base_q;

	logic [SB-1:0]       snd_idx;
	logic [AW-1:0]       addr_c;
	logic [WORD_W-1:0]   mask_c;
	logic                bit_rd;
	logic                bit_cur;
	logic [STATUS_W-1:0] cls_c;
	logic                set_ok;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [WORD_W-1:0]   mem_wdata;

	assign snd_idx = SB'(sender_q);
	// Word address: sender selects the row, the number modulo WINDOW selects the word.
	assign addr_c  = (AW'(snd_idx) << WB6) | AW'((pos_q >> BIT_W) & SEQ_W'(WPS - 1));
	assign mask_c  = WORD_W'(1) << pos_q[BIT_W-1:0];
	assign bit_rd  = rword_q[pos_q[BIT_W-1:0]];
	assign bit_cur = word_q[pos_q[BIT_W-1:0]];

	always_comb begin
		if (pos_q < base_q) begin
			cls_c = ST_DUP;
		end else if ((pos_q - base_q) >= SEQ_W'(WINDOW)) begin
			cls_c = ST_OVERRUN;
		end else if (bit_rd) begin
			cls_c = ST_DUP;
		end else begin
			cls_c = ST_OK;
		end
	end

	assign set_ok = in_range_q && (func_q == FUNC_SET) && (cls_c == ST_OK);

	assign stat.clr_done  = (clr_q == AW'(TOTAL - 1));
	assign stat.need_scan = set_ok && (pos_q == base_q);
	assign stat.scan_stop = !bit_cur;
	assign stat.scan_wrap = bit_cur && (pos_q[BIT_W-1:0] == BIT_W'(WORD_W - 1));
	assign stat.out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = waddr_q;
		mem_wdata = word_q;
		if (cmd.clr) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (cmd.eval && set_ok && (pos_q != base_q)) begin
			mem_we    = 1'b1;
			mem_wdata = rword_q | mask_c;
		end else if ((cmd.scan && !bit_cur) || cmd.wb) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bits_mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.rd) begin
			rword_q <= bits_mem[addr_c];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr && (32'(clr_q) < NUM_SENDERS)) begin
			base_mem[clr_q[SB-1:0]] <= '0;
		end else if (cmd.scan && !bit_cur) begin
			base_mem[snd_idx] <= pos_q;
		end
		if (cmd.rd && in_range_q) begin
			base_q <= base_mem[snd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr && !stat.clr_done) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q     <= in_func;
			sender_q   <= in_sender;
			in_range_q <= (32'(in_sender) < NUM_SENDERS);
			pos_q      <= in_seq;
		end
		if (cmd.rd) begin
			waddr_q <= addr_c;
		end
		if (cmd.eval) begin
			word_q <= rword_q | mask_c;
			if (!in_range_q) begin
				res_status_q <= ST_REJECT;
				res_base_q   <= '0;
			end else if (func_q == FUNC_SET && cls_c != ST_OK) begin
				res_status_q <= ST_REJECT;
				res_base_q   <= base_q;
			end else begin
				res_status_q <= cls_c;
				res_base_q   <= base_q;
			end
		end
		if (cmd.ldw) begin
			word_q <= rword_q;
		end
		if (cmd.scan) begin
			if (bit_cur) begin
				word_q <= word_q & ~(WORD_W'(1) << pos_q[BIT_W-1:0]);
				pos_q  <= pos_q + SEQ_W'(1);
			end else begin
				res_base_q <= pos_q;
			end
		end
		if (cmd.push) begin
			m_status_q <= res_status_q;
			m_base_q   <= res_base_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign out_status = m_status_q;
	assign out_base   = m_base_q;

endmodule

@@ rtl/per_sender_receive_window_tracker.sv @@
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: func; tdata: sender, seq_number
// m_*       out  m_tvalid/m_tready  tdata: status, window_base
//
// A check, or a set that does not move the base, passes through READ and EVAL,
// then waits in RESP until the output register is free, pushes its result there
// and returns to IDLE for the next item. A set that advances the base also runs
// SCAN, clearing set bits, plus WRITE, RDNEXT and LDNEXT each time the scan
// crosses into the next 64-bit bitmap word. After reset a clearing pass writes
// NUM_SENDERS*WINDOW/64 bitmap words (128 at the defaults), one per cycle, and
// s_tready stays low until it ends. One item is in work at a time; a result
// waiting in the output register does not block acceptance, only the delivery
// of the next result. WINDOW is a power of two.
module per_sender_receive_window_tracker
	import psrwt_pkg::*;
#(
	parameter int WINDOW      = DEF_WINDOW,
	parameter int NUM_SENDERS = DEF_NUM_SENDERS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // sender[3:0], seq_number[35:4], zero pad
	input  logic [0:0]            s_tuser,  // func[0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // status[1:0], window_base[33:2], zero pad
);

	cmd_t                cmd;
	stat_t               stat;
	logic [STATUS_W-1:0] out_status;
	logic [SEQ_W-1:0]    out_base;

	psrwt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.stat     (stat),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	psrwt_dp #(
		.WINDOW      (WINDOW),
		.NUM_SENDERS (NUM_SENDERS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_func    (s_tuser[0]),
		.in_sender  (s_tdata[SND_W-1:0]),
		.in_seq     (s_tdata[SND_W+SEQ_W-1:SND_W]),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.out_status (out_status),
		.out_base   (out_base),
		.stat       (stat)
	);

	assign m_tdata = {{(OUT_DATA_W - STATUS_W - SEQ_W){1'b0}}, out_base, out_status};

	// Only one item is in work: acceptance is followed by a busy cycle.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item accepted while another is in work");

	// A new result never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!m_tvalid || m_tready))
		else $error("result register overwritten");

	// No item is taken during the clearing pass.
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> !s_tready)
		else $error("input ready during clearing pass");

	// The input is ready only when the datapath is quiet.
	a_ready_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(cmd.scan || cmd.rd || cmd.eval || cmd.wb))
		else $error("input ready while item in work");

endmodule
